// ===== src/ssc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, codes and widths of the slave-serial configuration master.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int OP_W      = 3;
    localparam int STATUS_W  = 3;
    localparam int LIMIT_W   = 10;
    localparam int CFG_IDX_W = 1;
    localparam int BYTE_W    = 8;

    localparam int DEF_CLOCKS_PER_BURST = 64;
    localparam int DEF_CHECK_PERIOD     = 256;

    localparam logic [LIMIT_W-1:0] INIT_WAIT_RESET     = LIMIT_W'(100);
    localparam logic [LIMIT_W-1:0] STARTUP_BURST_RESET = LIMIT_W'(256);

    // operation codes
    localparam logic [OP_W-1:0] OP_START = 3'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd1;
    localparam logic [OP_W-1:0] OP_DATA  = 3'd2;
    localparam logic [OP_W-1:0] OP_END   = 3'd3;
    localparam logic [OP_W-1:0] OP_BURST = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INIT_WAIT_LIMIT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STARTUP_BURST_LIMIT = 1'd1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PROG  = 3'd1,
        PH_WAIT  = 3'd2,
        PH_LOAD  = 3'd3,
        PH_START = 3'd4
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_BUSY         = 3'd0,
        ST_READY        = 3'd1,
        ST_CONFIGURED   = 3'd2,
        ST_TIMEOUT      = 3'd3,
        ST_DONE_MISSING = 3'd4,
        ST_READ_ERROR   = 3'd5,
        ST_REJECTED     = 3'd6
    } t_status;

endpackage

// ===== src/ssc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_in_if
// Command channel: one operation item with its sampled pin levels.
// ----------------------------------------------------------------------------
interface ssc_in_if import ssc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data_byte;
    logic              init_level;
    logic              done_level;
    logic              read_error;

    modport source (output valid, operation, data_byte, init_level, done_level, read_error,
                    input ready);
    modport sink   (input valid, operation, data_byte, init_level, done_level, read_error,
                    output ready);
endinterface

// ===== src/ssc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_out_if
// Result channel: one configuration clock slot per item.
// ----------------------------------------------------------------------------
interface ssc_out_if import ssc_pkg::*;;
    logic                valid;
    logic                ready;
    logic                data_bit;
    logic                clock_pulse;
    logic                program_asserted;
    logic [STATUS_W-1:0] status;
    logic                init_dipped;
    logic                last;

    modport source (output valid, data_bit, clock_pulse, program_asserted, status,
                    init_dipped, last, input ready);
    modport sink   (input valid, data_bit, clock_pulse, program_asserted, status,
                    init_dipped, last, output ready);
endinterface

// ===== src/ssc_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface ssc_cfg_if import ssc_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [LIMIT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/slave_serial_config_master_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slave_serial_config_master_unit
// Master sequencer for slave-serial FPGA configuration.
//
// i_in_chan carries operations (start, millisecond tick, data byte, end of
// data, startup burst) with the sampled INIT/DONE levels. i_cfg_chan writes
// the INIT wait limit and the startup burst limit; it is always ready.
// o_out_chan gives one item per configuration clock slot, with last on the
// final item of each operation.
// An operation is decoded and the state updated in the cycle it is accepted;
// its results appear from the next cycle. A load-phase data byte gives 8
// items, a clocking burst CLOCKS_PER_BURST items, every other operation
// one item, at one item per cycle while not stalled. The result shift
// register is the only throughput limit: the next operation is accepted in
// the cycle the last item of the current one is taken, so operations follow
// back to back. When the receiver stalls, the current item holds and no new
// operation is accepted once the last item is pending. Reset clears the
// phase, counters and dip flag and restores limits of 100 and 256.
// ----------------------------------------------------------------------------
module slave_serial_config_master_unit import ssc_pkg::*; #(
    parameter int CLOCKS_PER_BURST = DEF_CLOCKS_PER_BURST,
    parameter int CHECK_PERIOD     = DEF_CHECK_PERIOD
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssc_in_if.sink    i_in_chan,
    ssc_cfg_if.sink   i_cfg_chan,
    ssc_out_if.source o_out_chan
);

    localparam int CNT_W = $clog2(CLOCKS_PER_BURST + 1);
    localparam int IDX_W = (CHECK_PERIOD > 1) ? $clog2(CHECK_PERIOD) : 1;

    // control state
    t_phase             r_phase, n_phase;
    logic [LIMIT_W-1:0] r_wait_cnt, n_wait_cnt;
    logic [IDX_W-1:0]   r_byte_idx, n_byte_idx;
    logic               r_dip, n_dip;
    logic [LIMIT_W-1:0] r_burst_cnt, n_burst_cnt;
    logic [LIMIT_W-1:0] r_init_limit;
    logic [LIMIT_W-1:0] r_burst_limit;

    // result shift stage
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_bits, n_bits;
    logic              r_fill, n_fill;
    logic              r_clk_pulse, n_clk_pulse;
    logic              r_prog, n_prog;
    t_status           r_status, n_status;
    logic              r_dip_old, n_dip_old;
    logic              r_dip_new, n_dip_new;

    logic in_accept;
    logic out_take;
    logic cnt_last;
    logic wait_timeout;
    logic burst_seen_done;
    logic burst_exhausted;

    assign cnt_last        = (r_cnt == CNT_W'(1));
    assign out_take        = o_out_chan.valid && o_out_chan.ready;
    assign i_in_chan.ready = (r_cnt == '0) || (cnt_last && o_out_chan.ready);
    assign in_accept       = i_in_chan.valid && i_in_chan.ready;
    assign i_cfg_chan.ready = 1'b1;

    assign wait_timeout    = (r_wait_cnt >= r_init_limit);
    assign burst_seen_done = (r_burst_cnt != '0) && i_in_chan.done_level;
    assign burst_exhausted = (r_burst_cnt >= r_burst_limit);

    // next state and counters
    always_comb begin
        n_phase     = r_phase;
        n_wait_cnt  = r_wait_cnt;
        n_byte_idx  = r_byte_idx;
        n_dip       = r_dip;
        n_burst_cnt = r_burst_cnt;
        case (i_in_chan.operation)
            OP_START: begin
                n_phase     = PH_PROG;
                n_wait_cnt  = '0;
                n_byte_idx  = '0;
                n_dip       = 1'b0;
                n_burst_cnt = '0;
            end
            OP_TICK: begin
                if (r_phase == PH_PROG) begin
                    n_phase    = PH_WAIT;
                    n_wait_cnt = '0;
                end else if (r_phase == PH_WAIT) begin
                    if (i_in_chan.init_level) begin
                        n_phase    = PH_LOAD;
                        n_byte_idx = '0;
                    end else if (wait_timeout) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_wait_cnt = r_wait_cnt + LIMIT_W'(1);
                    end
                end
            end
            OP_DATA: begin
                if (r_phase == PH_LOAD) begin
                    if (r_byte_idx == '0 && !i_in_chan.init_level) begin
                        n_dip = 1'b1;
                    end
                    if (r_byte_idx == IDX_W'(CHECK_PERIOD - 1)) begin
                        n_byte_idx = '0;
                    end else begin
                        n_byte_idx = r_byte_idx + IDX_W'(1);
                    end
                end
            end
            OP_END: begin
                if (r_phase == PH_LOAD) begin
                    if (i_in_chan.read_error) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase     = PH_START;
                        n_burst_cnt = '0;
                    end
                end
            end
            OP_BURST: begin
                if (r_phase == PH_START) begin
                    if (burst_seen_done || burst_exhausted) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_burst_cnt = r_burst_cnt + LIMIT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // results of the accepted operation
    always_comb begin
        n_cnt       = CNT_W'(1);
        n_bits      = '0;
        n_fill      = 1'b0;
        n_clk_pulse = 1'b0;
        n_prog      = (n_phase == PH_PROG);
        n_status    = ST_REJECTED;
        n_dip_old   = (i_in_chan.operation == OP_START) ? 1'b0 : r_dip;
        n_dip_new   = n_dip;
        case (i_in_chan.operation)
            OP_START: begin
                n_status = ST_BUSY;
            end
            OP_TICK: begin
                if (r_phase == PH_PROG) begin
                    n_status = ST_BUSY;
                end else if (r_phase == PH_WAIT) begin
                    if (i_in_chan.init_level) begin
                        n_status = ST_READY;
                    end else if (wait_timeout) begin
                        n_status = ST_TIMEOUT;
                    end else begin
                        n_status = ST_BUSY;
                    end
                end
            end
            OP_DATA: begin
                if (r_phase == PH_LOAD) begin
                    n_cnt       = CNT_W'(BYTE_W);
                    n_bits      = i_in_chan.data_byte;
                    n_clk_pulse = 1'b1;
                    n_status    = ST_READY;
                end
            end
            OP_END: begin
                if (r_phase == PH_LOAD) begin
                    n_status = i_in_chan.read_error ? ST_READ_ERROR : ST_BUSY;
                end
            end
            OP_BURST: begin
                if (r_phase == PH_START) begin
                    if (burst_seen_done) begin
                        n_status = ST_CONFIGURED;
                    end else if (burst_exhausted) begin
                        n_status = ST_DONE_MISSING;
                    end else begin
                        // all-ones startup clocks
                        n_cnt       = CNT_W'(CLOCKS_PER_BURST);
                        n_bits      = '1;
                        n_fill      = 1'b1;
                        n_clk_pulse = 1'b1;
                        n_status    = ST_BUSY;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_wait_cnt    <= '0;
            r_byte_idx    <= '0;
            r_dip         <= 1'b0;
            r_burst_cnt   <= '0;
            r_init_limit  <= INIT_WAIT_RESET;
            r_burst_limit <= STARTUP_BURST_RESET;
            r_cnt         <= '0;
        end else begin
            if (in_accept) begin
                r_phase     <= n_phase;
                r_wait_cnt  <= n_wait_cnt;
                r_byte_idx  <= n_byte_idx;
                r_dip       <= n_dip;
                r_burst_cnt <= n_burst_cnt;
                r_cnt       <= n_cnt;
            end else if (out_take) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cfg_chan.valid && i_cfg_chan.ready) begin
                unique case (i_cfg_chan.index)
                    REG_INIT_WAIT_LIMIT:     r_init_limit  <= i_cfg_chan.data;
                    REG_STARTUP_BURST_LIMIT: r_burst_limit <= i_cfg_chan.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_bits      <= n_bits;
            r_fill      <= n_fill;
            r_clk_pulse <= n_clk_pulse;
            r_prog      <= n_prog;
            r_status    <= n_status;
            r_dip_old   <= n_dip_old;
            r_dip_new   <= n_dip_new;
        end else if (out_take) begin
            // advance to the next bit, MSB first
            r_bits <= {r_bits[BYTE_W-2:0], r_fill};
        end
    end

    assign o_out_chan.valid            = (r_cnt != '0);
    assign o_out_chan.data_bit         = r_bits[BYTE_W-1];
    assign o_out_chan.clock_pulse      = r_clk_pulse;
    assign o_out_chan.program_asserted = r_prog;
    assign o_out_chan.status           = r_status;
    assign o_out_chan.init_dipped      = cnt_last ? r_dip_new : r_dip_old;
    assign o_out_chan.last             = cnt_last;

endmodule
